// ===== hdl/crcfr_pkg.sv =====
// Shared types, outcome codes and the CRC-8 byte update for the flood relay filter.
// Depends on nothing; every other file of the block imports it.
package crcfr_pkg;

   // One received packet byte with its framing mark.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       packet_start;
   } in_word_type;

   // One packet record, emitted on the eighth byte of a packet.
   typedef struct packed {
      logic [1:0]  outcome;
      logic [15:0] seq_index;
      logic [7:0]  hops_left;
      logic [7:0]  command_code;
      logic [7:0]  red_level;
      logic [7:0]  green_level;
      logic [7:0]  blue_level;
      logic [7:0]  relay_check;
   } out_word_type;

   // Record outcome codes.
   localparam logic [1:0] OUTCOME_CRC_ERROR = 2'd0;
   localparam logic [1:0] OUTCOME_STALE     = 2'd1;
   localparam logic [1:0] OUTCOME_NO_RELAY  = 2'd2;
   localparam logic [1:0] OUTCOME_RELAY     = 2'd3;

   // CRC-8 constants: polynomial x^8+x^5+x^4+1, zero start value, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // Byte positions within an eight-byte packet.
   localparam logic [2:0] POS_INDEX_HI = 3'd0;
   localparam logic [2:0] POS_TTL      = 3'd2;
   localparam logic [2:0] POS_COMMAND  = 3'd3;
   localparam logic [2:0] POS_RED      = 3'd4;
   localparam logic [2:0] POS_GREEN    = 3'd5;
   localparam logic [2:0] POS_BLUE     = 3'd6;
   localparam logic [2:0] POS_CHECK    = 3'd7;

   // Folds one byte into the running CRC, one bit per step.
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/crcfr_front.sv =====
// Front part: frames received bytes, runs both CRCs, holds the packet fields and
// classifies each complete packet into one record. Depends on crcfr_pkg.
module crcfr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_take,
   input  crcfr_pkg::in_word_type  in_word,
   output logic                  rec_push,
   output crcfr_pkg::out_word_type rec_word
);
   import crcfr_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  rel_crc_ff, rel_crc_in;
   logic [7:0]  index_hi_ff, index_hi_in;
   logic [7:0]  index_lo_ff, index_lo_in;
   logic [15:0] last_index_ff, last_index_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;

   logic [2:0]  pos;
   logic [7:0]  data;
   logic [7:0]  crc_base, rel_base, rel_data;
   logic [7:0]  crc_next, rel_next;
   logic [15:0] held_index;
   logic [7:0]  hops;
   logic [1:0]  outcome;

   // A start mark restarts framing on this very word.
   assign pos  = in_word.packet_start ? POS_INDEX_HI : pos_ff;
   assign data = in_word.rx_byte;

   // Both CRCs restart at the first byte; the relayed copy carries the decremented TTL.
   assign crc_base = (pos == POS_INDEX_HI) ? CRC_INIT : crc_ff;
   assign rel_base = (pos == POS_INDEX_HI) ? CRC_INIT : rel_crc_ff;
   assign rel_data = (pos == POS_TTL && data != 8'd0) ? data - 8'd1 : data;
   assign crc_next = crc8_feed(crc_base, data);
   assign rel_next = crc8_feed(rel_base, rel_data);

   // Classification of a complete packet on its check byte.
   assign held_index = {index_hi_ff, index_lo_ff};
   assign hops       = (ttl_ff == 8'd0) ? 8'd0 : ttl_ff - 8'd1;

   always_comb begin
      if (crc_ff != data) begin
         outcome = OUTCOME_CRC_ERROR;
      end else if (held_index <= last_index_ff) begin
         outcome = OUTCOME_STALE;
      end else if (ttl_ff == 8'd0) begin
         outcome = OUTCOME_NO_RELAY;
      end else begin
         outcome = OUTCOME_RELAY;
      end
   end

   assign rec_push              = in_take && (pos == POS_CHECK);
   assign rec_word.outcome      = outcome;
   assign rec_word.seq_index    = held_index;
   assign rec_word.hops_left    = hops;
   assign rec_word.command_code = command_ff;
   assign rec_word.red_level    = red_ff;
   assign rec_word.green_level  = green_ff;
   assign rec_word.blue_level   = blue_ff;
   assign rec_word.relay_check  = (outcome == OUTCOME_RELAY) ? rel_crc_ff : 8'd0;

   // Next-state logic for framing, CRCs and held fields.
   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      rel_crc_in    = rel_crc_ff;
      index_hi_in   = index_hi_ff;
      index_lo_in   = index_lo_ff;
      last_index_in = last_index_ff;
      ttl_in        = ttl_ff;
      command_in    = command_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      if (in_take) begin
         if (pos == POS_CHECK) begin
            pos_in = POS_INDEX_HI;
            if (outcome == OUTCOME_NO_RELAY || outcome == OUTCOME_RELAY) begin
               last_index_in = held_index;
            end
         end else begin
            pos_in     = pos + 3'd1;
            crc_in     = crc_next;
            rel_crc_in = rel_next;
            case (pos)
               POS_INDEX_HI: begin
                  index_hi_in = data;
                  index_lo_in = 8'd0;
               end
               POS_TTL:     ttl_in     = data;
               POS_COMMAND: command_in = data;
               POS_RED:     red_in     = data;
               POS_GREEN:   green_in   = data;
               POS_BLUE:    blue_in    = data;
               default:     index_lo_in = data;
            endcase
         end
      end
   end

   // Control state and index registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_INDEX_HI;
         crc_ff        <= CRC_INIT;
         rel_crc_ff    <= CRC_INIT;
         index_hi_ff   <= 8'd0;
         index_lo_ff   <= 8'd0;
         last_index_ff <= 16'd0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         rel_crc_ff    <= rel_crc_in;
         index_hi_ff   <= index_hi_in;
         index_lo_ff   <= index_lo_in;
         last_index_ff <= last_index_in;
      end
   end

   // Payload fields; each is written before any check byte can read it.
   always_ff @(posedge clock) begin
      ttl_ff     <= ttl_in;
      command_ff <= command_in;
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
   end

endmodule

// ===== hdl/crcfr_queue.sv =====
// Back part: a short record queue that holds finished records until they are taken.
// Depends on crcfr_pkg for the record type.
module crcfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  crcfr_pkg::out_word_type push_word,
   output logic                    full,
   output logic                    empty,
   input  logic                    pop,
   output crcfr_pkg::out_word_type pop_word
);
   import crcfr_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   out_word_type       slots [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = slots[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/crc_checked_flood_relay_filter.sv =====
// A record is readable in the cycle after the word holding its check byte is taken.
// One word per cycle unless req_full; req_full rises only while QUEUE_DEPTH records wait.
// The front classifies a packet in the cycle of its check byte and writes the record queue.
// Reset (synchronous, active high) clears framing, both CRCs, the last accepted index
// and the record queue; the block takes words in the first cycle after reset.
module crc_checked_flood_relay_filter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  crcfr_pkg::in_word_type  req_word,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output crcfr_pkg::out_word_type rsp_word
);
   import crcfr_pkg::*;

   logic         take;
   logic         rec_push;
   out_word_type rec_word;

   // A word is taken whenever the record queue has room.
   assign take = req_push && !req_full;

   crcfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (take),
      .in_word  (req_word),
      .rec_push (rec_push),
      .rec_word (rec_word)
   );

   crcfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_word (rec_word),
      .full      (req_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_word  (rsp_word)
   );

endmodule

// ===== hdl/crcfr_checker.sv =====
// Port-level checks of the flood relay filter, attached to the top level by bind.
// Depends on crcfr_pkg.
module crcfr_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_push,
   input logic                    req_full,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input crcfr_pkg::out_word_type rsp_word
);
   import crcfr_pkg::*;

   // After reset nothing waits and the block takes words at once.
   a_reset_clears : assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queue not cleared by reset");

   // A record cannot appear unless a word was taken in the previous cycle.
   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_empty) && !rsp_empty) |-> ($past(req_push) && !$past(req_full)))
      else $error("record appeared without a taken word");

   // Relay check byte is zero unless the packet is relayed.
   a_relay_check : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.outcome != OUTCOME_RELAY) |-> (rsp_word.relay_check == 8'd0))
      else $error("relay check byte set on a non-relay record");

   // An accepted packet without relay had TTL zero, so no hops are left.
   a_no_relay_hops : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.outcome == OUTCOME_NO_RELAY) |-> (rsp_word.hops_left == 8'd0))
      else $error("non-relay record reports hops left");

   // A waiting record that is not taken stays in place.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("waiting record changed before it was taken");

endmodule

bind crc_checked_flood_relay_filter crcfr_checker u_checker (.*);
